[hw/rtl/cffsa_pkg.sv]
// Shared types and constants of the circular first-free slot allocator.
package cffsa_pkg;

    localparam int SLOT_W           = 10;   // slot index field
    localparam int CNT_W            = 11;   // slot count register
    localparam int BIT_W            = 5;    // bit index within a flag word
    localparam int WORD_BITS        = 32;   // flags per memory word
    localparam int SLOT_FIELD_LIMIT = 1024; // slots reachable by a 10-bit index

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // capture request
        logic    rd;          // read selected flag word
        logic    commit;      // write back updated word, refresh summary
        logic    mark;        // current word searched without a hit
        logic    to_lo;       // start wrapped part of the search
        logic    emit;        // latch result
        status_t emit_status;
        logic    out_load;    // move result into output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic range_err;
        logic is_release;
        logic cand_any;
        logic phase_lo;
        logic hit;
    } dp_stat_t;

endpackage

[hw/rtl/cffsa_datapath.sv]
// Datapath: flag word memory, full-word summary, search masks and result registers.
module cffsa_datapath #(
    parameter int SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cffsa_pkg::dp_cmd_t            cmd,
    output cffsa_pkg::dp_stat_t           stat,
    input  logic                          action,
    input  logic [cffsa_pkg::SLOT_W-1:0]  position,
    input  logic [cffsa_pkg::CNT_W-1:0]   num_slots,
    output logic [cffsa_pkg::SLOT_W-1:0]  slot,
    output logic [1:0]                    status
);

    localparam int ACT       = (SLOTS < cffsa_pkg::SLOT_FIELD_LIMIT) ? SLOTS
                                                                     : cffsa_pkg::SLOT_FIELD_LIMIT;
    localparam int WORDS_RAW = (ACT + cffsa_pkg::WORD_BITS - 1) / cffsa_pkg::WORD_BITS;
    localparam int WORDS     = (WORDS_RAW < 2) ? 2 : WORDS_RAW;
    localparam int WIDX      = $clog2(WORDS);

    localparam int WB  = cffsa_pkg::WORD_BITS;
    localparam int BW  = cffsa_pkg::BIT_W;
    localparam int CW  = cffsa_pkg::CNT_W;
    localparam int SW  = cffsa_pkg::SLOT_W;

    // request
    cffsa_pkg::action_t  action_reg;
    logic [SW-1:0]       pos_reg;

    // search control
    logic                phase_lo_reg;
    logic [WORDS-1:0]    checked_reg;
    logic [WORDS-1:0]    full_reg;
    logic [WORDS-1:0]    wvalid_reg;
    logic                rvalid_reg;

    // flag storage
    logic [WB-1:0]       mem [WORDS];
    logic [WB-1:0]       rdata_reg;
    logic [WIDX-1:0]     cur_reg;

    // results
    logic [SW-1:0]       res_slot_reg;
    cffsa_pkg::status_t  res_status_reg;
    logic [SW-1:0]       out_slot_reg;
    cffsa_pkg::status_t  out_status_reg;

    logic [CW-1:0]       n;
    logic [CW-1:0]       nm1;
    logic [BW-1:0]       w0_full;
    logic [BW-1:0]       wl_full;
    logic [WIDX-1:0]     w0;
    logic [WIDX-1:0]     wl;
    logic [BW-1:0]       lo;
    logic [BW-1:0]       lastbit;
    logic                is_release;
    logic [WORDS-1:0]    cand_vec;
    logic [WIDX-1:0]     cand_idx;
    logic [WIDX-1:0]     sel_word;
    logic [WB-1:0]       word;
    logic [WB-1:0]       free_vec;
    logic [BW-1:0]       hit_bit;
    logic                hit;
    logic [WB-1:0]       new_word;

    // effective count and window bounds
    assign n       = (num_slots > CW'(ACT)) ? CW'(ACT) : num_slots;
    assign nm1     = n - CW'(1);
    assign w0_full = pos_reg[SW-1:BW];
    assign wl_full = nm1[SW-1:BW];
    assign w0      = w0_full[WIDX-1:0];
    assign wl      = wl_full[WIDX-1:0];
    assign lo      = pos_reg[BW-1:0];
    assign lastbit = nm1[BW-1:0];

    assign is_release = (action_reg == cffsa_pkg::ACT_RELEASE);

    // candidate words: not full, not yet searched, inside the current window
    always_comb
    begin
        for (int j = 0; j < WORDS; j++)
        begin
            cand_vec[j] = !full_reg[j] && !checked_reg[j] &&
                          (phase_lo_reg ? (WIDX'(j) <= w0)
                                        : ((WIDX'(j) >= w0) && (WIDX'(j) <= wl)));
        end
    end

    always_comb
    begin
        cand_idx = '0;
        for (int j = WORDS - 1; j >= 0; j--)
        begin
            if (cand_vec[j])
            begin
                cand_idx = WIDX'(j);
            end
        end
    end

    assign sel_word = is_release ? w0 : cand_idx;

    // masked free bits of the word just read
    assign word = rvalid_reg ? rdata_reg : '0;

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            free_vec[i] = !word[i] &&
                          ((cur_reg != w0) ||
                           (phase_lo_reg ? (BW'(i) < lo) : (BW'(i) >= lo))) &&
                          ((cur_reg != wl) || (BW'(i) <= lastbit));
        end
    end

    always_comb
    begin
        hit_bit = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                hit_bit = BW'(i);
            end
        end
    end

    assign hit      = |free_vec;
    assign new_word = is_release ? (word & ~(WB'(1) << lo)) : (word | (WB'(1) << hit_bit));

    assign stat.range_err  = ({1'b0, pos_reg} >= n);
    assign stat.is_release = is_release;
    assign stat.cand_any   = |cand_vec;
    assign stat.phase_lo   = phase_lo_reg;
    assign stat.hit        = hit;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_lo_reg <= 1'b0;
            checked_reg  <= '0;
            full_reg     <= '0;
            wvalid_reg   <= '0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_lo_reg <= 1'b0;
                checked_reg  <= '0;
            end
            if (cmd.to_lo)
            begin
                phase_lo_reg <= 1'b1;
                checked_reg  <= '0;
            end
            if (cmd.mark)
            begin
                checked_reg[cur_reg] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rvalid_reg <= wvalid_reg[sel_word];
            end
            if (cmd.commit)
            begin
                wvalid_reg[cur_reg] <= 1'b1;
                full_reg[cur_reg]   <= &new_word;
            end
        end
    end

    // payload, memory and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= cffsa_pkg::action_t'(action);
            pos_reg    <= position;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[sel_word];
            cur_reg   <= sel_word;
        end
        if (cmd.commit)
        begin
            mem[cur_reg] <= new_word;
        end
        if (cmd.emit)
        begin
            res_status_reg <= cmd.emit_status;
            if (cmd.emit_status == cffsa_pkg::ST_OK && !is_release)
            begin
                res_slot_reg <= {BW'(cur_reg), hit_bit};
            end
            else
            begin
                res_slot_reg <= pos_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_slot_reg   <= res_slot_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign slot   = out_slot_reg;
    assign status = out_status_reg;

    a_alloc_commit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !is_release) |-> hit)
        else $error("allocation committed without a free in-window slot");

    a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (cur_reg <= wl))
        else $error("word read beyond the last slot in use");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && res_status_reg == cffsa_pkg::ST_OK && !is_release)
            |-> ({1'b0, res_slot_reg} < n))
        else $error("granted slot outside the slots in use");

endmodule

[hw/rtl/cffsa_ctrl.sv]
// Controller: request sequencing, search phases and output register handshake.
module cffsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cffsa_pkg::dp_stat_t stat,
    output cffsa_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEL  = 4'b0010,
        S_CHK  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = cffsa_pkg::ST_OK;
        state_next      = state_reg;
        in_ready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (stat.range_err)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = cffsa_pkg::ST_RANGE;
                    state_next      = S_OUT;
                end
                else if (stat.is_release || stat.cand_any)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHK;
                end
                else if (!stat.phase_lo)
                begin
                    cmd.to_lo = 1'b1;
                end
                else
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = cffsa_pkg::ST_FULL;
                    state_next      = S_OUT;
                end
            end
            S_CHK:
            begin
                if (stat.is_release || stat.hit)
                begin
                    cmd.commit = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mark   = 1'b1;
                    state_next = S_SEL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_full_only_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_status == cffsa_pkg::ST_FULL) |-> stat.phase_lo)
        else $error("all-busy reported before the wrapped search");

    a_no_read_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> !stat.range_err)
        else $error("flag read for an out-of-range position");

endmodule

[hw/rtl/circular_first_free_slot_allocator.sv]
// Top level of the circular first-free slot allocator: slot count register and unit wiring.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    action, position
//  out      source     out_valid / out_ready  slot, status
//  cfg      sink       cfg_valid / cfg_ready  num_slots
//
// After acceptance, an out-of-range position goes straight to the output stage; otherwise
// each flag word visited (at most three words) is read and then checked, the search wraps
// when the upper part holds no free slot, and all busy is reported when the wrapped part
// holds none either; the result then moves into the output register.
// The controller then returns to idle, where it accepts the next transaction.
// Reset clears every busy flag at once through per-word valid bits; num_slots resets to 1024.
// A result waiting on out_ready does not block acceptance of the next transaction; the
// next result then holds until the output register empties.
// cfg_ready is always high; the slot count may be written only while the block is idle.
module circular_first_free_slot_allocator #(
    parameter int SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [cffsa_pkg::SLOT_W-1:0]  position,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cffsa_pkg::SLOT_W-1:0]  slot,
    output logic [1:0]                    status,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cffsa_pkg::CNT_W-1:0]   num_slots
);

    logic [cffsa_pkg::CNT_W-1:0] num_slots_reg;
    logic [cffsa_pkg::CNT_W-1:0] num_slots_next;
    cffsa_pkg::dp_cmd_t          cmd;
    cffsa_pkg::dp_stat_t         stat;

    // slot count register, writable on any cycle the cfg transaction completes
    assign cfg_ready      = 1'b1;
    assign num_slots_next = (cfg_valid && cfg_ready) ? num_slots : num_slots_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_slots_reg <= cffsa_pkg::CNT_W'(cffsa_pkg::SLOT_FIELD_LIMIT);
        end
        else
        begin
            num_slots_reg <= num_slots_next;
        end
    end

    // sequencer
    cffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // flag storage and search
    cffsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .position  (position),
        .num_slots (num_slots_reg),
        .slot      (slot),
        .status    (status)
    );

endmodule

[bench/tb.sv]
// Self-checking testbench for the circular first-free slot allocator.
module tb;

    localparam int SLOTS          = 1024;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 100;
    localparam int SETTLE_CYCLES  = 12;    // worst-case request latency plus margin
    localparam int HOLD_CYCLES    = 300;   // long out_ready hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any accepted transaction

    // one expected result
    typedef struct {
        logic [cffsa_pkg::SLOT_W-1:0] slot;
        cffsa_pkg::status_t           status;
    } grant_t;

    // one row of the directed table; a reconfig row writes the slot count first
    typedef struct {
        bit                           reconfig;
        logic [cffsa_pkg::CNT_W-1:0]  count;
        cffsa_pkg::action_t           act;
        logic [cffsa_pkg::SLOT_W-1:0] pos;
        bit                           typed;
        logic [cffsa_pkg::SLOT_W-1:0] exp_slot;
        cffsa_pkg::status_t           exp_status;
    } row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         action;
    logic [cffsa_pkg::SLOT_W-1:0] position;
    logic                         out_valid;
    logic                         out_ready;
    logic [cffsa_pkg::SLOT_W-1:0] slot;
    logic [1:0]                   status;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [cffsa_pkg::CNT_W-1:0]  num_slots;

    // typed expectation travelling with the transaction on offer
    logic                         row_typed;
    logic [cffsa_pkg::SLOT_W-1:0] row_slot;
    cffsa_pkg::status_t           row_status;

    // predictor state: leaf busy flags (all free at start) and the slot count register
    bit                           slot_busy [SLOTS];
    logic [cffsa_pkg::CNT_W-1:0]  slot_count = 11'd1024;

    grant_t                       pending_grants [$];
    row_t                         directed_rows [$];
    int                           errors = 0;
    int                           idle_cycles = 0;
    bit                           calm;                 // no idling on either side
    bit                           hold_request = 1'b0;  // ask the receiver for a long hold-off

    circular_first_free_slot_allocator #(
        .SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .position (position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot     (slot),
        .status   (status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .num_slots(num_slots)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Predicted effect of one request: linear circular scan over the leaf flags.
    // The full-word summary only speeds the search up, so the leaves alone carry the behavior.
    task automatic predict_grant(input logic act, input logic [cffsa_pkg::SLOT_W-1:0] pos,
                                 output grant_t g);
        int  n;
        int  cand;
        int  i;
        bit  found;
        n = (slot_count > SLOTS) ? SLOTS : int'(slot_count);
        if (n > cffsa_pkg::SLOT_FIELD_LIMIT)
            n = cffsa_pkg::SLOT_FIELD_LIMIT;
        g.slot   = pos;
        g.status = cffsa_pkg::ST_OK;
        found    = 1'b0;
        if (int'(pos) >= n)
        begin
            // out of range, including a slot count of zero: nothing changes
            g.status = cffsa_pkg::ST_RANGE;
        end
        else if (act == cffsa_pkg::ACT_RELEASE)
        begin
            // releasing a free slot is harmless
            slot_busy[pos] = 1'b0;
        end
        else
        begin
            for (i = 0; i < n && !found; i++)
            begin
                cand = int'(pos) + i;
                if (cand >= n)
                    cand -= n;
                if (!slot_busy[cand])
                begin
                    slot_busy[cand] = 1'b1;
                    g.slot          = cand[cffsa_pkg::SLOT_W-1:0];
                    found           = 1'b1;
                end
            end
            if (!found)
                g.status = cffsa_pkg::ST_FULL;
        end
    endtask

    // Monitor: results are checked before new requests are queued, so a result
    // showing up on an empty queue is never masked by a same-cycle request.
    always @(posedge clk)
    begin
        grant_t g;
        grant_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    report_mismatch("unexpected result, slot", int'(slot), -1);
                end
                else
                begin
                    want = pending_grants[0];
                    pending_grants.delete(0);
                    if (slot !== want.slot)
                        report_mismatch("slot", int'(slot), int'(want.slot));
                    if (status !== want.status)
                        report_mismatch("status", int'(status), int'(want.status));
                end
            end
            if (cfg_valid && cfg_ready)
                slot_count = num_slots;
            if (in_valid && in_ready)
            begin
                // the predictor always runs to keep its flags in step
                predict_grant(action, position, g);
                if (row_typed)
                begin
                    g.slot   = row_slot;
                    g.status = row_status;
                end
                pending_grants.insert(pending_grants.size(), g);
            end
        end
    end

    // Watchdog: any accepted transaction on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, no back-pressure while calm, and one long
    // hold-off counted here so that the block fills up and drops in_ready.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // Offer one request; returns at the edge where it was accepted.
    // in_valid is left high so the next offer can follow without a gap.
    task automatic send_request(input cffsa_pkg::action_t act,
                                input logic [cffsa_pkg::SLOT_W-1:0] pos,
                                input bit typed, input logic [cffsa_pkg::SLOT_W-1:0] es,
                                input cffsa_pkg::status_t est);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        position   <= pos;
        row_typed  <= typed;
        row_slot   <= es;
        row_status <= est;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // Slot count write, only once the block has drained.
    task automatic write_slot_count(input logic [cffsa_pkg::CNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        num_slots <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input bit reconfig, input int count, input cffsa_pkg::action_t act,
                           input int pos, input bit typed, input int es,
                           input cffsa_pkg::status_t est);
        row_t r;
        r.reconfig   = reconfig;
        r.count      = count[cffsa_pkg::CNT_W-1:0];
        r.act        = act;
        r.pos        = pos[cffsa_pkg::SLOT_W-1:0];
        r.typed      = typed;
        r.exp_slot   = es[cffsa_pkg::SLOT_W-1:0];
        r.exp_status = est;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    initial
    begin
        int                           n;
        int                           alloc_pct;
        logic [cffsa_pkg::CNT_W-1:0]  count;
        logic [cffsa_pkg::SLOT_W-1:0] pos;
        cffsa_pkg::action_t           act;
        row_t                         r;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = 1'b0;
        position     = '0;
        cfg_valid    = 1'b0;
        num_slots    = '0;
        row_typed    = 1'b0;
        row_slot     = '0;
        row_status   = cffsa_pkg::ST_OK;
        calm         = 1'b0;

        // directed table; the typed rows are plain to read off, the rest use the predictor
        // reset state: 1024 slots, all free
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   0,    1, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   1023, 1, 1023, cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   1023, 0, 0,    cffsa_pkg::ST_OK); // wraps
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   0,    0, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 1023, 1, 1023, cffsa_pkg::ST_OK);
        // release of a free slot
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 1023, 1, 1023, cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 700,  1, 700,  cffsa_pkg::ST_OK);
        // count above the field limit behaves as 1024
        add_row(1, 2047, cffsa_pkg::ACT_ALLOC,   1023, 1, 1023, cffsa_pkg::ST_OK);
        // single slot, already busy
        add_row(1, 1,    cffsa_pkg::ACT_ALLOC,   0,    1, 0,    cffsa_pkg::ST_FULL);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   1,    1, 1,    cffsa_pkg::ST_RANGE);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 0,    1, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   0,    1, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 1023, 1, 1023, cffsa_pkg::ST_RANGE);
        // zero slots: everything out of range
        add_row(1, 0,    cffsa_pkg::ACT_ALLOC,   0,    1, 0,    cffsa_pkg::ST_RANGE);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 0,    1, 0,    cffsa_pkg::ST_RANGE);
        // four slots; last slot as search start
        add_row(1, 4,    cffsa_pkg::ACT_ALLOC,   3,    1, 3,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   3,    1, 3,    cffsa_pkg::ST_FULL);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 1,    1, 1,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   3,    0, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 3,    1, 3,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_ALLOC,   2,    0, 0,    cffsa_pkg::ST_OK);
        // shrink: flag of slot 3 kept but not searched
        add_row(1, 3,    cffsa_pkg::ACT_ALLOC,   2,    0, 0,    cffsa_pkg::ST_OK);
        // grow back: slot 3 still busy
        add_row(1, 1024, cffsa_pkg::ACT_ALLOC,   3,    0, 0,    cffsa_pkg::ST_OK);
        add_row(0, 0,    cffsa_pkg::ACT_RELEASE, 4,    0, 0,    cffsa_pkg::ST_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            r = directed_rows[k];
            if (r.reconfig)
                write_slot_count(r.count);
            send_request(r.act, r.pos, r.typed, r.exp_slot, r.exp_status);
        end

        // random phases over a spread of slot counts, extremes among them
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       count = 11'd1024;
                1:       count = 11'd2;
                2:       count = 11'd1;
                3:       count = 11'd5;
                4:       count = 11'd2047;
                5:       count = 11'd33;
                6:       count = 11'd0;
                7:       count = 11'($urandom_range(0, 2047));
                8:       count = 11'd3;
                9:       count = 11'd1000;
                10:      count = 11'd64;
                11:      count = 11'd16;
                12:      count = 11'd1023;
                13:      count = 11'd7;
                14:      count = 11'd512;
                default: count = 11'($urandom_range(1, 40));
            endcase
            write_slot_count(count);
            n         = (count > 1024) ? 1024 : int'(count);
            alloc_pct = (p % 3 == 0) ? 85 : 55;   // some phases push toward full
            calm      = (p >= 8 && p <= 10);      // long stretch with no idling
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 4 && k == 10)
                    hold_request = 1'b1;
                act = ($urandom_range(0, 99) < alloc_pct) ? cffsa_pkg::ACT_ALLOC
                                                          : cffsa_pkg::ACT_RELEASE;
                if (n > 0 && $urandom_range(0, 99) < 80)
                    pos = cffsa_pkg::SLOT_W'($urandom_range(0, n - 1));
                else
                    pos = cffsa_pkg::SLOT_W'($urandom_range(0, 1023));
                send_request(act, pos, 1'b0, '0, cffsa_pkg::ST_OK);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
